[sv/input_event_ring_device_macros.svh]
// Assertion macros shared by the input event ring device files.
`ifndef INPUT_EVENT_RING_DEVICE_MACROS_SVH
`define INPUT_EVENT_RING_DEVICE_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define IED_HOLDS(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define IED_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/ied_pkg.sv]
// Types and constants of the input event ring device.
package ied_pkg;

  typedef enum logic [1:0] {
    ACT_POST   = 2'd0,
    ACT_MOTION = 2'd1,
    ACT_READ   = 2'd2,
    ACT_WRITE  = 2'd3
  } act_e;

  typedef enum logic [1:0] {
    FAULT_NONE  = 2'd0,
    FAULT_LOAD  = 2'd1,
    FAULT_STORE = 2'd2
  } fault_e;

  typedef enum logic [1:0] {
    CFG_DEVICE_ID   = 2'd0,
    CFG_VERSION     = 2'd1,
    CFG_BTN_FIRST   = 2'd2,
    CFG_BTN_LAST    = 2'd3
  } cfg_idx_e;

  // Word index of a register in the bus map (byte offset bits 4:2).
  typedef enum logic [2:0] {
    REG_ID      = 3'd0,
    REG_VERSION = 3'd1,
    REG_PENDING = 3'd2,
    REG_EVENT   = 3'd3,
    REG_LOST    = 3'd4,
    REG_ABS_X   = 3'd5,
    REG_ABS_Y   = 3'd6,
    REG_BUTTONS = 3'd7
  } reg_sel_e;

  localparam logic [3:0]  ACCESS_WORD     = 4'd4;
  localparam logic [31:0] VERSION_RESET   = 32'd1;
  localparam logic [15:0] BTN_FIRST_RESET = 16'd272;
  localparam logic [15:0] BTN_LAST_RESET  = 16'd274;

  typedef struct packed {
    logic push;
    logic pop;
  } ring_ctrl_t;

  typedef struct packed {
    logic empty;
    logic full;
  } ring_stat_t;

  // Event word: valid flag, low 15 bits of the value, code.
  function automatic logic [31:0] event_word(input logic [15:0] code,
                                             input logic [31:0] value);
    event_word = {1'b1, value[14:0], code};
  endfunction

endpackage

[sv/ied_cell.sv]
// One storage cell of the event chain.
module ied_cell
  import ied_pkg::*;
(
  input  logic        clk_i,
  input  logic        shift_i,
  input  logic        load_i,
  input  logic [31:0] nbr_i,
  input  logic [31:0] push_word_i,
  output logic [31:0] word_o
);

  logic [31:0] word_q, word_d;

  // Advance toward the head on a pop, take the new event when it lands here.
  always_comb begin
    word_d = word_q;
    if (shift_i) begin
      word_d = nbr_i;
    end else if (load_i) begin
      word_d = push_word_i;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o = word_q;

endmodule

[sv/ied_ring.sv]
// Event queue built as a chain of cells with the oldest event in cell 0.
module ied_ring
  import ied_pkg::*;
#(
  parameter int RING_DEPTH = 64
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  ring_ctrl_t                           ctrl_i,
  input  logic [31:0]                          push_word_i,
  output logic [31:0]                          head_word_o,
  output logic [$clog2(RING_DEPTH+1)-1:0]      count_o,
  output ring_stat_t                           stat_o
);

  `include "input_event_ring_device_macros.svh"

  localparam int CntW = $clog2(RING_DEPTH + 1);

  logic [CntW-1:0] cnt_q, cnt_d;
  logic [31:0]     words [RING_DEPTH];
  logic            full;

  assign full = (cnt_q == CntW'(RING_DEPTH));

  for (genvar i = 0; i < RING_DEPTH; i++) begin : g_cell
    logic [31:0] nbr;
    if (i == RING_DEPTH - 1) begin : g_tail
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = words[i+1];
    end

    ied_cell u_cell (
      .clk_i       (clk_i),
      .shift_i     (ctrl_i.pop),
      .load_i      (ctrl_i.push && (cnt_q == CntW'(i))),
      .nbr_i       (nbr),
      .push_word_i (push_word_i),
      .word_o      (words[i])
    );
  end

  always_comb begin
    cnt_d = cnt_q;
    if (ctrl_i.push && !ctrl_i.pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (ctrl_i.pop && !ctrl_i.push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  assign head_word_o  = words[0];
  assign count_o      = cnt_q;
  assign stat_o.empty = (cnt_q == '0);
  assign stat_o.full  = full;

  `IED_HOLDS(a_cnt_max, 1'b1, cnt_q <= CntW'(RING_DEPTH), "event count beyond depth")
  `IED_HOLDS(a_push_room, ctrl_i.push, !full, "push into a full chain")
  `IED_NEXT(a_cnt_step, ctrl_i.push && !ctrl_i.pop, cnt_q == ($past(cnt_q) + CntW'(1)), "count did not advance on push")

endmodule

[sv/input_event_ring_device.sv]
// Top level of the input event ring device: bus registers, buttons, event chain.
//
// Input device whose events a bus master drains word by word. Every command
// is taken in a single transfer: busy_o stays low, so a command is taken at
// each rising edge where start_i is high, one per cycle with no gaps. A bus
// read or bus write command produces exactly one result, shown on
// read_data_o and fault_o with valid_o high for the single cycle right after
// the command; post and motion commands produce none. The receiver cannot
// stall, so it must capture the result in that cycle. The event queue is a
// row of RING_DEPTH cells with the oldest event in the first cell; a read of
// the event register shifts the whole row by one, a post loads the cell just
// past the last pending event, so each command touches the queue once and
// the rate is fixed at one command per clock. Configuration writes are
// always ready and take effect at the edge of the transfer.
module input_event_ring_device
  import ied_pkg::*;
#(
  parameter int RING_DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // command channel
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  action_i,
  input  logic [15:0] event_code_i,
  input  logic [31:0] event_value_i,
  input  logic [31:0] pos_x_i,
  input  logic [31:0] pos_y_i,
  input  logic [11:0] byte_offset_i,
  input  logic [3:0]  access_size_i,
  // result channel
  output logic        valid_o,
  output logic [31:0] read_data_o,
  output logic [1:0]  fault_o,
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  `include "input_event_ring_device_macros.svh"

  localparam int CntW = $clog2(RING_DEPTH + 1);

  // Configuration registers
  logic [31:0] device_id_q, version_q;
  logic [15:0] btn_first_q, btn_last_q;

  // Device state
  logic [31:0] lost_q, lost_d;
  logic [31:0] abs_x_q, abs_y_q;
  logic [31:0] buttons_q, buttons_d;

  // Result register
  logic        valid_q, valid_d;
  logic [31:0] rdata_q, rdata_d;
  fault_e      fault_q, fault_d;

  // Queue interface
  ring_ctrl_t      ring_ctrl;
  ring_stat_t      ring_stat;
  logic [31:0]     head_word;
  logic [CntW-1:0] ring_count;

  logic        accept;
  act_e        act;
  logic        size_ok, aligned_ok, access_ok, in_map;
  reg_sel_e    sel;
  logic [15:0] btn_offs;
  logic        is_button;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start_i && !busy_o;
  assign act         = act_e'(action_i);

  // Only aligned full-word accesses inside the map reach a register.
  assign size_ok    = (access_size_i == ACCESS_WORD);
  assign aligned_ok = (byte_offset_i[1:0] == 2'b00);
  assign access_ok  = size_ok && aligned_ok;
  assign in_map     = (byte_offset_i[11:5] == '0);
  assign sel        = reg_sel_e'(byte_offset_i[4:2]);

  // A code in [first, last] with an offset below 32 maps to a button bit.
  assign btn_offs  = event_code_i - btn_first_q;
  assign is_button = (event_code_i >= btn_first_q) && (event_code_i <= btn_last_q)
                     && (btn_offs[15:5] == '0);

  always_comb begin
    ring_ctrl = '0;
    lost_d    = lost_q;
    buttons_d = buttons_q;
    valid_d   = 1'b0;
    rdata_d   = '0;
    fault_d   = FAULT_NONE;

    if (accept) begin
      case (act)
        ACT_POST: begin
          if (ring_stat.full) begin
            // drop the newest event and count it
            lost_d = lost_q + 32'd1;
          end else begin
            ring_ctrl.push = 1'b1;
            if (is_button) begin
              buttons_d[btn_offs[4:0]] = (event_value_i != '0);
            end
          end
        end
        ACT_MOTION: begin
          // position is taken in the clocked block
        end
        ACT_READ: begin
          valid_d = 1'b1;
          if (!access_ok) begin
            fault_d = FAULT_LOAD;
          end else if (in_map) begin
            case (sel)
              REG_ID:      rdata_d = device_id_q;
              REG_VERSION: rdata_d = version_q;
              REG_PENDING: rdata_d = 32'(ring_count);
              REG_EVENT: begin
                // dequeue the head; an empty queue reads 0
                if (!ring_stat.empty) begin
                  rdata_d       = head_word;
                  ring_ctrl.pop = 1'b1;
                end
              end
              REG_LOST: begin
                rdata_d = lost_q;
                lost_d  = '0;
              end
              REG_ABS_X:   rdata_d = abs_x_q;
              REG_ABS_Y:   rdata_d = abs_y_q;
              REG_BUTTONS: rdata_d = buttons_q;
              default:     rdata_d = '0;
            endcase
          end
        end
        ACT_WRITE: begin
          // writes change nothing; only refuse misaligned or odd sizes
          valid_d = 1'b1;
          if (!access_ok) begin
            fault_d = FAULT_STORE;
          end
        end
        default: begin
        end
      endcase
    end
  end

  ied_ring #(
    .RING_DEPTH (RING_DEPTH)
  ) u_ring (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ring_ctrl),
    .push_word_i (event_word(event_code_i, event_value_i)),
    .head_word_o (head_word),
    .count_o     (ring_count),
    .stat_o      (ring_stat)
  );

  // Configuration transfers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      device_id_q <= '0;
      version_q   <= VERSION_RESET;
      btn_first_q <= BTN_FIRST_RESET;
      btn_last_q  <= BTN_LAST_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_DEVICE_ID: device_id_q <= cfg_data_i;
        CFG_VERSION:   version_q   <= cfg_data_i;
        CFG_BTN_FIRST: btn_first_q <= cfg_data_i[15:0];
        CFG_BTN_LAST:  btn_last_q  <= cfg_data_i[15:0];
        default: begin
        end
      endcase
    end
  end

  // Device state and result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lost_q    <= '0;
      abs_x_q   <= '0;
      abs_y_q   <= '0;
      buttons_q <= '0;
      valid_q   <= 1'b0;
    end else begin
      lost_q    <= lost_d;
      buttons_q <= buttons_d;
      valid_q   <= valid_d;
      if (accept && (act == ACT_MOTION)) begin
        abs_x_q <= pos_x_i;
        abs_y_q <= pos_y_i;
      end
    end
  end

  // Result payload, held only for the strobe cycle
  always_ff @(posedge clk_i) begin
    rdata_q <= rdata_d;
    fault_q <= fault_d;
  end

  assign valid_o     = valid_q;
  assign read_data_o = rdata_q;
  assign fault_o     = fault_q;

  `IED_NEXT(a_bus_result, accept && action_i[1], valid_q, "bus access gave no result")
  `IED_NEXT(a_no_result, !(accept && action_i[1]), !valid_q, "result without bus access")
  `IED_NEXT(a_lost_clear, accept && (act == ACT_READ) && access_ok && in_map && (sel == REG_LOST),
            lost_q == '0, "lost counter not cleared by its read")

endmodule

[dv/tb_input_event_ring_device.sv]
// Self-checking testbench for the input event ring device.
`timescale 1ns / 100ps

module tb_input_event_ring_device;
  import ied_pkg::*;

  localparam int RING_DEPTH = 64;
  localparam int CLK_HALF   = 5;
  localparam int ITEMS_PER_PHASE = 134;

  // One command transfer, plus an optional hand-typed reply for the directed rows.
  typedef struct {
    act_e        act;
    logic [15:0] code;
    logic [31:0] value;
    logic [31:0] px;
    logic [31:0] py;
    logic [11:0] off;
    logic [3:0]  size;
    bit          typed;
    logic [31:0] want_data;
    fault_e      want_fault;
  } cmd_t;

  typedef struct {
    logic [31:0] data;
    fault_e      fault;
  } reply_t;

  // Drive every input to a known value from time zero.
  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        start_i       = 1'b0;
  logic [1:0]  action_i      = ACT_POST;
  logic [15:0] event_code_i  = '0;
  logic [31:0] event_value_i = '0;
  logic [31:0] pos_x_i       = '0;
  logic [31:0] pos_y_i       = '0;
  logic [11:0] byte_offset_i = '0;
  logic [3:0]  access_size_i = '0;
  logic        cfg_valid_i   = 1'b0;
  logic [1:0]  cfg_index_i   = CFG_DEVICE_ID;
  logic [31:0] cfg_data_i    = '0;
  logic        busy_o;
  logic        valid_o;
  logic [31:0] read_data_o;
  logic [1:0]  fault_o;
  logic        cfg_ready_o;

  // Typed reply that travels with the command currently on the ports.
  bit          cmd_typed     = 1'b0;
  logic [31:0] cmd_want_data = '0;
  fault_e      cmd_want_fault = FAULT_NONE;

  // Shadow copy of the device: event ring, counters, pointer, buttons, settings.
  logic [31:0] ev_ring [RING_DEPTH];
  int unsigned ev_head   = 0;
  int unsigned ev_count  = 0;
  logic [31:0] lost_cnt  = '0;
  logic [31:0] abs_x_q   = '0;
  logic [31:0] abs_y_q   = '0;
  logic [31:0] btn_bits  = '0;
  logic [31:0] dev_id    = '0;
  logic [31:0] ver_word  = VERSION_RESET;
  logic [15:0] btn_first = BTN_FIRST_RESET;
  logic [15:0] btn_last  = BTN_LAST_RESET;

  // Bus replies still owed by the device, oldest first.
  reply_t bus_replies [$];
  int     mismatches = 0;

  input_event_ring_device #(
    .RING_DEPTH (RING_DEPTH)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .action_i      (action_i),
    .event_code_i  (event_code_i),
    .event_value_i (event_value_i),
    .pos_x_i       (pos_x_i),
    .pos_y_i       (pos_y_i),
    .byte_offset_i (byte_offset_i),
    .access_size_i (access_size_i),
    .valid_o       (valid_o),
    .read_data_o   (read_data_o),
    .fault_o       (fault_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #CLK_HALF clk_i = ~clk_i;

  // Hard stop well past the slowest legal run.
  initial begin
    #2_000_000;
    $display("tb_input_event_ring_device: FAIL");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: mismatch on %s: got %h, want %h", $realtime, what, got, want);
    mismatches++;
  endtask

  function automatic cmd_t row(input act_e act, input logic [15:0] code,
                               input logic [31:0] value, input logic [31:0] px,
                               input logic [31:0] py, input logic [11:0] off,
                               input logic [3:0] size, input bit typed,
                               input logic [31:0] want_data, input fault_e want_fault);
    cmd_t c;
    c.act        = act;
    c.code       = code;
    c.value      = value;
    c.px         = px;
    c.py         = py;
    c.off        = off;
    c.size       = size;
    c.typed      = typed;
    c.want_data  = want_data;
    c.want_fault = want_fault;
    return c;
  endfunction

  // Advance the shadow device by one command; return the bus reply if there is one.
  task automatic run_device_cmd(input act_e act, input logic [15:0] code,
                                input logic [31:0] value, input logic [31:0] px,
                                input logic [31:0] py, input logic [11:0] off,
                                input logic [3:0] size, output bit has_reply,
                                output reply_t rep);
    logic [15:0] offs;
    bit          word_ok;
    word_ok   = (size == ACCESS_WORD) && (off[1:0] == 2'b00);
    has_reply = 1'b0;
    rep.data  = '0;
    rep.fault = FAULT_NONE;
    case (act)
      ACT_POST: begin
        if (ev_count >= RING_DEPTH) begin
          // Full ring: drop the event, count it, leave the buttons alone.
          lost_cnt = lost_cnt + 32'd1;
        end else begin
          // An inverted range fails at least one compare, so no code is a button then.
          if (code >= btn_first && code <= btn_last) begin
            offs = code - btn_first;
            if (offs < 16'd32) btn_bits[offs[4:0]] = (value != '0);
          end
          ev_ring[(ev_head + ev_count) % RING_DEPTH] = {1'b1, value[14:0], code};
          ev_count++;
        end
      end
      ACT_MOTION: begin
        abs_x_q = px;
        abs_y_q = py;
      end
      ACT_READ: begin
        has_reply = 1'b1;
        if (!word_ok) begin
          rep.fault = FAULT_LOAD;
        end else if (off[11:5] == '0) begin
          case (reg_sel_e'(off[4:2]))
            REG_ID:      rep.data = dev_id;
            REG_VERSION: rep.data = ver_word;
            REG_PENDING: rep.data = 32'(ev_count);
            REG_EVENT: begin
              // Empty ring reads zero and pops nothing.
              if (ev_count != 0) begin
                rep.data = ev_ring[ev_head];
                ev_head  = (ev_head + 1) % RING_DEPTH;
                ev_count--;
              end
            end
            REG_LOST: begin
              rep.data = lost_cnt;
              lost_cnt = '0;
            end
            REG_ABS_X:   rep.data = abs_x_q;
            REG_ABS_Y:   rep.data = abs_y_q;
            REG_BUTTONS: rep.data = btn_bits;
            default:     rep.data = '0;
          endcase
        end
      end
      default: begin
        // Bus write: never changes state, only the size and alignment check matters.
        has_reply = 1'b1;
        rep.fault = word_ok ? FAULT_NONE : FAULT_STORE;
      end
    endcase
  endtask

  // Sample at the rising edge: check the reply on the ports, then take the new
  // command and configuration transfers into the shadow device.
  always @(posedge clk_i) begin : monitor
    reply_t want;
    reply_t rep;
    bit     has_reply;
    if (rst_ni) begin
      if (valid_o) begin
        if (bus_replies.size() == 0) begin
          report_mismatch("reply with none pending", read_data_o, '0);
        end else begin
          want = bus_replies.pop_front();
          if (read_data_o !== want.data) report_mismatch("read_data", read_data_o, want.data);
          if (fault_o !== want.fault) report_mismatch("fault", 32'(fault_o), 32'(want.fault));
        end
      end
      if (start_i && !busy_o) begin
        run_device_cmd(act_e'(action_i), event_code_i, event_value_i, pos_x_i, pos_y_i,
                       byte_offset_i, access_size_i, has_reply, rep);
        if (has_reply) begin
          if (cmd_typed) begin
            rep.data  = cmd_want_data;
            rep.fault = cmd_want_fault;
          end
          bus_replies.push_back(rep);
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_DEVICE_ID: dev_id    = cfg_data_i;
          CFG_VERSION:   ver_word  = cfg_data_i;
          CFG_BTN_FIRST: btn_first = cfg_data_i[15:0];
          CFG_BTN_LAST:  btn_last  = cfg_data_i[15:0];
          default: ;
        endcase
      end
    end
  end

  // Present one command at the falling edge and hold it until the transfer.
  // Idle first for a random number of cycles; leave start_i high on return.
  task automatic drive_cmd(input cmd_t c, input int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(negedge clk_i);
    end
    start_i        <= 1'b1;
    action_i       <= c.act;
    event_code_i   <= c.code;
    event_value_i  <= c.value;
    pos_x_i        <= c.px;
    pos_y_i        <= c.py;
    byte_offset_i  <= c.off;
    access_size_i  <= c.size;
    cmd_typed      <= c.typed;
    cmd_want_data  <= c.want_data;
    cmd_want_fault <= c.want_fault;
    do @(posedge clk_i); while (busy_o);
    @(negedge clk_i);
  endtask

  // Hold one register write until its transfer; the caller drops cfg_valid_i.
  task automatic write_cfg(input cfg_idx_e idx, input logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
  endtask

  // Drop start_i and wait until every owed reply is back.
  task automatic drain_replies();
    start_i <= 1'b0;
    while (bus_replies.size() != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
  endtask

  initial begin : stimulus
    cmd_t        directed [$];
    int          idle_pct;
    int          left;
    int          k;
    int          sel;
    int          guard;
    logic [15:0] code;
    logic [31:0] val;
    logic [11:0] off;
    logic [3:0]  size;
    act_e        act;

    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset values, every register, faults, unmapped offsets, then button posts, a motion and readbacks.
    directed.push_back(row(ACT_READ, '0, '0, '0, '0, 12'h000, ACCESS_WORD, 1, 32'd0, FAULT_NONE));
    directed.push_back(row(ACT_READ, '0, '0, '0, '0, 12'h004, ACCESS_WORD, 1, 32'd1, FAULT_NONE));
    directed.push_back(row(ACT_READ, '0, '0, '0, '0, 12'h008, ACCESS_WORD, 1, 32'd0, FAULT_NONE));
    directed.push_back(row(ACT_READ, '0, '0, '0, '0, 12'h00C, ACCESS_WORD, 1, 32'd0, FAULT_NONE));
    directed.push_back(row(ACT_READ, '0, '0, '0, '0, 12'h010, ACCESS_WORD, 1, 32'd0, FAULT_NONE));
    directed.push_back(row(ACT_READ, '0, '0, '0, '0, 12'h014, ACCESS_WORD, 1, 32'd0, FAULT_NONE));
    directed.push_back(row(ACT_READ, '0, '0, '0, '0, 12'h018, ACCESS_WORD, 1, 32'd0, FAULT_NONE));
    directed.push_back(row(ACT_READ, '0, '0, '0, '0, 12'h01C, ACCESS_WORD, 1, 32'd0, FAULT_NONE));
    directed.push_back(row(ACT_READ, '0, '0, '0, '0, 12'h000, 4'd2, 1, 32'd0, FAULT_LOAD));
    directed.push_back(row(ACT_READ, '0, '0, '0, '0, 12'h002, ACCESS_WORD, 1, 32'd0, FAULT_LOAD));
    directed.push_back(row(ACT_READ, '0, '0, '0, '0, 12'h004, 4'd8, 1, 32'd0, FAULT_LOAD));
    directed.push_back(row(ACT_READ, '1, '1, '1, '1, 12'hFFF, 4'hF, 1, 32'd0, FAULT_LOAD));
    directed.push_back(row(ACT_READ, '0, '0, '0, '0, 12'hFFC, ACCESS_WORD, 1, 32'd0, FAULT_NONE));
    directed.push_back(row(ACT_READ, '0, '0, '0, '0, 12'h020, ACCESS_WORD, 1, 32'd0, FAULT_NONE));
    directed.push_back(row(ACT_WRITE, '0, '0, '0, '0, 12'h000, ACCESS_WORD, 1, 32'd0, FAULT_NONE));
    directed.push_back(row(ACT_WRITE, '0, '0, '0, '0, 12'h001, ACCESS_WORD, 1, 32'd0, FAULT_STORE));
    directed.push_back(row(ACT_WRITE, '0, '0, '0, '0, 12'h00C, 4'd0, 1, 32'd0, FAULT_STORE));
    directed.push_back(row(ACT_POST, 16'd272, 32'd1, '0, '0, '0, '0, 0, '0, FAULT_NONE));
    directed.push_back(row(ACT_POST, 16'd274, 32'hFFFF_FFFF, '0, '0, '0, '0, 0, '0, FAULT_NONE));
    directed.push_back(row(ACT_POST, 16'hFFFF, 32'h0000_8000, '0, '0, '0, '0, 0, '0, FAULT_NONE));
    directed.push_back(row(ACT_POST, 16'd0, 32'd0, '0, '0, '0, '0, 0, '0, FAULT_NONE));
    directed.push_back(row(ACT_MOTION, '0, '0, 32'hFFFF_FFFF, 32'd0, '0, '0, 0, '0, FAULT_NONE));
    directed.push_back(row(ACT_READ, '0, '0, '0, '0, 12'h01C, ACCESS_WORD, 0, '0, FAULT_NONE));
    directed.push_back(row(ACT_READ, '0, '0, '0, '0, 12'h008, ACCESS_WORD, 0, '0, FAULT_NONE));
    directed.push_back(row(ACT_READ, '0, '0, '0, '0, 12'h014, ACCESS_WORD, 0, '0, FAULT_NONE));
    foreach (directed[i]) drive_cmd(directed[i], 0);

    // Random phases: sender gaps of 19 percent, then 60, then none. Each phase
    // runs under its own settings, extremes and an inverted button range among them.
    for (int phase = 0; phase < 6; phase++) begin
      idle_pct = (phase < 2) ? 19 : (phase < 4) ? 60 : 0;
      drain_replies();
      case (phase)
        0: begin
          write_cfg(CFG_DEVICE_ID, 32'hFFFF_FFFF);
          write_cfg(CFG_VERSION, 32'd0);
          write_cfg(CFG_BTN_FIRST, 32'd0);
          write_cfg(CFG_BTN_LAST, 32'd31);
        end
        1: begin
          write_cfg(CFG_DEVICE_ID, $urandom);
          write_cfg(CFG_VERSION, $urandom);
          write_cfg(CFG_BTN_FIRST, 32'd65535);
          write_cfg(CFG_BTN_LAST, 32'd65535);
        end
        2: begin
          // Inverted range: no code is a button.
          write_cfg(CFG_BTN_FIRST, 32'd300);
          write_cfg(CFG_BTN_LAST, 32'd200);
        end
        3: begin
          // Codes past first + 31 still enqueue but touch no bit.
          write_cfg(CFG_BTN_FIRST, 32'd65500);
          write_cfg(CFG_BTN_LAST, 32'd65535);
        end
        4: begin
          write_cfg(CFG_DEVICE_ID, 32'd0);
          write_cfg(CFG_VERSION, 32'hFFFF_FFFF);
          write_cfg(CFG_BTN_FIRST, 32'd0);
          write_cfg(CFG_BTN_LAST, 32'd65535);
        end
        default: begin
          write_cfg(CFG_VERSION, VERSION_RESET);
          write_cfg(CFG_BTN_FIRST, BTN_FIRST_RESET);
          write_cfg(CFG_BTN_LAST, BTN_LAST_RESET);
        end
      endcase
      cfg_valid_i <= 1'b0;
      @(negedge clk_i);

      left = ITEMS_PER_PHASE;
      while (left > 0) begin
        sel = $urandom_range(99);
        if (sel < 40) begin
          // Post burst; a long one now and then to overrun the ring.
          k = ($urandom_range(9) == 0) ? $urandom_range(60, 80) : $urandom_range(1, 8);
          repeat (k) begin
            code = ($urandom_range(3) == 0) ? 16'($urandom)
                                            : 16'(btn_first + $urandom_range(40) - 4);
            val  = ($urandom_range(2) == 0) ? 32'd0 : $urandom;
            drive_cmd(row(ACT_POST, code, val, $urandom, $urandom, 12'($urandom),
                          4'($urandom), 0, '0, FAULT_NONE), idle_pct);
          end
        end else if (sel < 70) begin
          // Drain burst: mostly event pops, with pending and lost reads mixed in.
          k = ($urandom_range(7) == 0) ? $urandom_range(40, 70) : $urandom_range(1, 10);
          repeat (k) begin
            sel = $urandom_range(19);
            off = (sel < 17) ? 12'h00C : (sel < 19) ? 12'h008 : 12'h010;
            drive_cmd(row(ACT_READ, 16'($urandom), $urandom, $urandom, $urandom, off,
                          ACCESS_WORD, 0, '0, FAULT_NONE), idle_pct);
          end
        end else if (sel < 88) begin
          // Single register access, mostly well formed.
          k    = 1;
          act  = ($urandom_range(4) == 0) ? ACT_WRITE : ACT_READ;
          off  = ($urandom_range(9) == 0) ? 12'($urandom) : 12'($urandom_range(7) << 2);
          size = ($urandom_range(9) == 0) ? 4'($urandom) : ACCESS_WORD;
          drive_cmd(row(act, 16'($urandom), $urandom, $urandom, $urandom, off, size,
                        0, '0, FAULT_NONE), idle_pct);
        end else begin
          // Noise: a motion or a command with every field random.
          k   = 1;
          act = ($urandom_range(1) == 0) ? ACT_MOTION : act_e'($urandom_range(3));
          drive_cmd(row(act, 16'($urandom), $urandom, $urandom, $urandom, 12'($urandom),
                        4'($urandom), 0, '0, FAULT_NONE), idle_pct);
        end
        left -= k;
      end
    end

    // Let the last replies come back, then wait on for stray strobes.
    start_i <= 1'b0;
    guard = 0;
    while (bus_replies.size() != 0 && guard < 100) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (3) @(posedge clk_i);
    if (bus_replies.size() != 0)
      report_mismatch("replies never returned", 32'(bus_replies.size()), '0);

    if (mismatches == 0) begin
      $display("tb_input_event_ring_device: PASS");
    end else begin
      $display("tb_input_event_ring_device: FAIL");
    end
    $finish;
  end

endmodule
